// ----- design/prsched_pkg.sv -----
// ----------------------------------------------------------------------------
// prsched_pkg: shared types and codes for the aging priority scheduler
// Request codes, entry state codes, controller states and the per-step
// control bundle that the controller hands to the entry update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package prsched_pkg;

  localparam logic [2:0] REQ_PICK      = 3'd0;
  localparam logic [2:0] REQ_ADMIT     = 3'd1;
  localparam logic [2:0] REQ_FINISH    = 3'd2;
  localparam logic [2:0] REQ_SET_PRIO  = 3'd3;
  localparam logic [2:0] REQ_SET_STATE = 3'd4;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_RUNNABLE = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;
  localparam logic [2:0] ST_LAST     = 3'd4;

  // table depth; the slot ports are sized for it
  localparam int unsigned NUM_ENTRIES = 64;

  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned EXT_W   = 9;

  localparam logic [1:0] CFG_PRIO_MIN     = 2'd0;
  localparam logic [1:0] CFG_PRIO_MAX     = 2'd1;
  localparam logic [1:0] CFG_PRIO_DEFAULT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } fsm_e;

  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       mark_pass;
    logic       bad_prio;
  } step_ctl_t;

endpackage

`default_nettype wire

// ----- design/prsched_cell.sv -----
// ----------------------------------------------------------------------------
// prsched_cell: one table entry in the rotating ring
// Holds state, id, base priority and boost; loads its neighbor on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module prsched_cell #(
  parameter int unsigned PRIO_BITS = 5,
  parameter int unsigned ID_BITS   = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  shift_i,
  input  wire [2:0]            state_i,
  input  wire [ID_BITS-1:0]    id_i,
  input  wire [PRIO_BITS-1:0]  base_i,
  input  wire [PRIO_BITS-1:0]  boost_i,
  output logic [2:0]           state_o,
  output logic [ID_BITS-1:0]   id_o,
  output logic [PRIO_BITS-1:0] base_o,
  output logic [PRIO_BITS-1:0] boost_o
);
  import prsched_pkg::*;

  logic [2:0]           state_q;
  logic [ID_BITS-1:0]   id_q;
  logic [PRIO_BITS-1:0] base_q, boost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_UNUSED;
      id_q    <= '0;
      base_q  <= PRIO_BITS'(10);
      boost_q <= '0;
    end else if (shift_i) begin
      state_q <= state_i;
      id_q    <= id_i;
      base_q  <= base_i;
      boost_q <= boost_i;
    end
  end

  assign state_o = state_q;
  assign id_o    = id_q;
  assign base_o  = base_q;
  assign boost_o = boost_q;

endmodule

`default_nettype wire

// ----- design/prsched_alu.sv -----
// ----------------------------------------------------------------------------
// prsched_alu: entry update at the head of the ring
// Apply the request to the entry passing by and compare it for pick.
// ----------------------------------------------------------------------------
`default_nettype none

module prsched_alu #(
  parameter int unsigned PRIO_BITS = 5,
  parameter int unsigned ID_BITS   = 16
) (
  input  wire prsched_pkg::step_ctl_t ctl_i,
  input  wire [PRIO_BITS-1:0]  prio_max_i,
  input  wire [PRIO_BITS-1:0]  prio_default_i,
  input  wire [ID_BITS-1:0]    req_id_i,
  input  wire [PRIO_BITS-1:0]  req_base_i,
  input  wire [PRIO_BITS-1:0]  req_boost_i,
  input  wire [2:0]            req_state_i,
  input  wire                  have_i,
  input  wire [PRIO_BITS-1:0]  best_eff_i,
  input  wire [ID_BITS-1:0]    best_id_i,
  input  wire [2:0]            state_i,
  input  wire [ID_BITS-1:0]    id_i,
  input  wire [PRIO_BITS-1:0]  base_i,
  input  wire [PRIO_BITS-1:0]  boost_i,
  output logic [2:0]           state_o,
  output logic [ID_BITS-1:0]   id_o,
  output logic [PRIO_BITS-1:0] base_o,
  output logic [PRIO_BITS-1:0] boost_o,
  output logic                 better_o,
  output logic [PRIO_BITS-1:0] eff_o
);
  import prsched_pkg::*;

  logic [PRIO_BITS:0] sum;
  logic               can_age;

  assign sum   = {1'b0, base_i} + {1'b0, boost_i};
  assign eff_o = (sum > {1'b0, prio_max_i}) ? prio_max_i : sum[PRIO_BITS-1:0];

  assign can_age = (base_i < prio_max_i) && (boost_i < (prio_max_i - base_i));

  assign better_o = (state_i == ST_RUNNABLE) &&
                    (!have_i || (eff_o > best_eff_i) ||
                     ((eff_o == best_eff_i) && (id_i < best_id_i)));

  always_comb begin
    state_o = state_i;
    id_o    = id_i;
    base_o  = base_i;
    boost_o = boost_i;
    case (ctl_i.op)
      REQ_PICK: begin
        if (ctl_i.mark_pass && ctl_i.hit) begin
          state_o = ST_RUNNING;
          boost_o = '0;
        end
      end
      REQ_ADMIT: begin
        if (ctl_i.hit) begin
          state_o = ST_RUNNABLE;
          id_o    = req_id_i;
          base_o  = req_base_i;
          boost_o = req_boost_i;
        end
      end
      REQ_FINISH, REQ_SET_STATE: begin
        if (ctl_i.hit) begin
          if (req_state_i <= ST_LAST) begin
            state_o = req_state_i;
            if (req_state_i == ST_UNUSED) begin
              base_o  = prio_default_i;
              boost_o = '0;
            end
          end
        end else if (ctl_i.op == REQ_FINISH && state_i == ST_RUNNABLE && can_age) begin
          boost_o = boost_i + PRIO_BITS'(1);
        end
      end
      REQ_SET_PRIO: begin
        if (ctl_i.hit && !ctl_i.bad_prio) begin
          base_o  = req_base_i;
          boost_o = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/priority_scheduler_with_aging.sv -----
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging: task table with priority pick and aging
// A ring of entry cells rotates past one update unit, one entry a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i / in_stall_o with their fields on separate
//   ports; one result per request leaves on out_valid_o / out_stall_i.
//   Configuration (prio_min, prio_max, prio_default) is written over the
//   APB-style port at byte addresses 0, 4 and 8 while the block is idle.
// Walk:
//   Every request rotates the whole ring once; a pick rotates it twice
//   (search, then mark the winner). The result is then registered; once it
//   leaves, the block returns to idle and only then takes the next request.
//   Each walk feeds the ring through the single update unit, one entry per
//   cycle.
// Reset:
//   All entries become unused with id 0, base 10 and boost 0; the registers
//   return to 0, 31 and 10. No clearing pass is needed.
// Stall:
//   A result holds in the output register until taken; no new request is
//   taken until then.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_scheduler_with_aging #(
  parameter int unsigned PRIO_BITS   = 5,
  parameter int unsigned ID_BITS     = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // request channel
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire [2:0]            req_type_i,
  input  wire [5:0]            slot_i,
  input  wire [ID_BITS-1:0]    task_id_i,
  input  wire [PRIO_BITS-1:0]  base_prio_i,
  input  wire [PRIO_BITS-1:0]  init_boost_i,
  input  wire [2:0]            new_state_i,
  // result channel
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 found_o,
  output logic [5:0]           chosen_slot_o,
  output logic [ID_BITS-1:0]   chosen_id_o,
  output logic [PRIO_BITS-1:0] chosen_eff_prio_o,
  output logic                 error_o,
  // configuration
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [3:0]            paddr,
  input  wire [31:0]           pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import prsched_pkg::*;

  localparam int unsigned CW = (NUM_ENTRIES > 2) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [CW-1:0] LAST = CW'(NUM_ENTRIES - 1);

  // configuration registers
  logic [PRIO_BITS-1:0] prio_min_q, prio_max_q, prio_default_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_min_q     <= '0;
      prio_max_q     <= PRIO_BITS'(31);
      prio_default_q <= PRIO_BITS'(10);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        CFG_PRIO_MIN:     prio_min_q     <= pwdata[PRIO_BITS-1:0];
        CFG_PRIO_MAX:     prio_max_q     <= pwdata[PRIO_BITS-1:0];
        CFG_PRIO_DEFAULT: prio_default_q <= pwdata[PRIO_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_PRIO_MIN:     prdata = 32'(prio_min_q);
      CFG_PRIO_MAX:     prdata = 32'(prio_max_q);
      CFG_PRIO_DEFAULT: prdata = 32'(prio_default_q);
      default:          prdata = '0;
    endcase
  end

  // controller
  fsm_e                 fsm_q;
  logic [CW-1:0]        cnt_q;
  logic                 pass_q;
  logic [2:0]           op_q;
  logic [5:0]           slot_q;
  logic [ID_BITS-1:0]   id_q;
  logic [PRIO_BITS-1:0] base_q, boost_q;
  logic [2:0]           nstate_q;
  logic                 bad_q;
  logic                 have_q;
  logic [CW-1:0]        best_q;
  logic [PRIO_BITS-1:0] best_eff_q;
  logic [ID_BITS-1:0]   best_id_q;

  logic                 in_acc, running, last_step;
  logic                 in_table;
  logic [EXT_W-1:0]     cnt_ext, slot_ext, best_ext;
  step_ctl_t            ctl;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (fsm_q != S_IDLE);
  assign running   = (fsm_q == S_RUN);
  assign last_step = running && (cnt_q == LAST);

  assign cnt_ext  = EXT_W'(cnt_q);
  assign slot_ext = EXT_W'(slot_q);
  assign best_ext = EXT_W'(best_q);
  assign in_table = (slot_ext < EXT_W'(NUM_ENTRIES));

  assign ctl.op        = op_q;
  assign ctl.mark_pass = pass_q;
  assign ctl.bad_prio  = bad_q;
  assign ctl.hit       = (op_q == REQ_PICK) ? (have_q && (cnt_q == best_q))
                                            : (in_table && (cnt_ext == slot_ext));

  // ring of entry cells; cell 0 is the head, the tail loads the updated entry
  logic [2:0]           c_state [NUM_ENTRIES+1];
  logic [ID_BITS-1:0]   c_id    [NUM_ENTRIES+1];
  logic [PRIO_BITS-1:0] c_base  [NUM_ENTRIES+1];
  logic [PRIO_BITS-1:0] c_boost [NUM_ENTRIES+1];
  logic                 better;
  logic [PRIO_BITS-1:0] eff;

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_ring
    prsched_cell #(.PRIO_BITS(PRIO_BITS), .ID_BITS(ID_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (running),
      .state_i (c_state[g+1]),
      .id_i    (c_id[g+1]),
      .base_i  (c_base[g+1]),
      .boost_i (c_boost[g+1]),
      .state_o (c_state[g]),
      .id_o    (c_id[g]),
      .base_o  (c_base[g]),
      .boost_o (c_boost[g])
    );
  end

  prsched_alu #(.PRIO_BITS(PRIO_BITS), .ID_BITS(ID_BITS)) u_alu (
    .ctl_i          (ctl),
    .prio_max_i     (prio_max_q),
    .prio_default_i (prio_default_q),
    .req_id_i       (id_q),
    .req_base_i     (base_q),
    .req_boost_i    (boost_q),
    .req_state_i    (nstate_q),
    .have_i         (have_q),
    .best_eff_i     (best_eff_q),
    .best_id_i      (best_id_q),
    .state_i        (c_state[0]),
    .id_i           (c_id[0]),
    .base_i         (c_base[0]),
    .boost_i        (c_boost[0]),
    .state_o        (c_state[NUM_ENTRIES]),
    .id_o           (c_id[NUM_ENTRIES]),
    .base_o         (c_base[NUM_ENTRIES]),
    .boost_o        (c_boost[NUM_ENTRIES]),
    .better_o       (better),
    .eff_o          (eff)
  );

  // hold request fields for the whole walk
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= req_type_i;
      slot_q   <= slot_i;
      id_q     <= task_id_i;
      base_q   <= base_prio_i;
      boost_q  <= init_boost_i;
      nstate_q <= new_state_i;
      bad_q    <= (EXT_W'(slot_i) >= EXT_W'(NUM_ENTRIES)) ||
                  (base_prio_i < prio_min_q) || (base_prio_i > prio_max_q);
    end
    if (running && op_q == REQ_PICK && !pass_q && better) begin
      best_q     <= cnt_q;
      best_eff_q <= eff;
      best_id_q  <= c_id[0];
    end
  end

  logic [EXT_W-1:0] best_slot_ext;
  assign best_slot_ext = best_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      have_q      <= 1'b0;
      out_valid_o <= 1'b0;
      found_o           <= 1'b0;
      chosen_slot_o     <= '0;
      chosen_id_o       <= '0;
      chosen_eff_prio_o <= '0;
      error_o           <= 1'b0;
    end else begin
      case (fsm_q)
        S_IDLE: begin
          if (in_acc) begin
            fsm_q  <= S_RUN;
            cnt_q  <= '0;
            pass_q <= 1'b0;
            have_q <= 1'b0;
          end
        end
        S_RUN: begin
          // advance the ring one entry
          cnt_q <= cnt_q + CW'(1);
          if (op_q == REQ_PICK && !pass_q && better) begin
            have_q <= 1'b1;
          end
          if (last_step) begin
            cnt_q <= '0;
            if (op_q == REQ_PICK && !pass_q) begin
              pass_q <= 1'b1;
            end else begin
              fsm_q       <= S_OUT;
              out_valid_o <= 1'b1;
              found_o           <= (op_q == REQ_PICK) && have_q;
              chosen_slot_o     <= (op_q == REQ_PICK && have_q) ? best_slot_ext[5:0] : '0;
              chosen_id_o       <= (op_q == REQ_PICK && have_q) ? best_id_q : '0;
              chosen_eff_prio_o <= (op_q == REQ_PICK && have_q) ? best_eff_q : '0;
              error_o           <= (op_q == REQ_SET_PRIO) && bad_q;
            end
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            fsm_q       <= S_IDLE;
          end
        end
        default: fsm_q <= S_IDLE;
      endcase
    end
  end

  // a result never coexists with an open request slot
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("result shown while idle");

  // a result leaves only when it was not stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");

  // pick fields and error never appear together
  a_err_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> !found_o) else $error("error on pick result");

endmodule

`default_nettype wire

// ----- sim/priority_scheduler_with_aging_tb.sv -----
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_tb: self-checking bench for the aging scheduler
// A clocked driver feeds requests from a pending queue, and a clocked monitor
// checks every result against a scheduler model kept in the bench. Random
// gaps and stalls hit both channels. The register settings change between
// phases, and only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_scheduler_with_aging_tb;
  import prsched_pkg::*;

  localparam int unsigned NENT = 64;
  localparam logic [2:0] REQ_UNKNOWN = 3'd5;
  localparam logic [2:0] ST_SLEEPING = 3'd1;

  typedef struct packed {
    logic [2:0]  req;
    logic [5:0]  slot;
    logic [15:0] tid;
    logic [4:0]  bp;
    logic [4:0]  ib;
    logic [2:0]  ns;
  } sched_req_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic [15:0] tid;
    logic [4:0]  eff;
    logic        err;
  } sched_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sched_req_t  cur_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found, error;
  logic [5:0]  chosen_slot;
  logic [15:0] chosen_id;
  logic [4:0]  chosen_eff;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  priority_scheduler_with_aging uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(cur_req.req), .slot_i(cur_req.slot), .task_id_i(cur_req.tid),
    .base_prio_i(cur_req.bp), .init_boost_i(cur_req.ib), .new_state_i(cur_req.ns),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .found_o(found), .chosen_slot_o(chosen_slot), .chosen_id_o(chosen_id),
    .chosen_eff_prio_o(chosen_eff), .error_o(error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Scheduler model: registers and task table as the block should hold them.
  logic [4:0]  mdl_min, mdl_max, mdl_default;
  logic [2:0]  tbl_state [NENT];
  logic [15:0] tbl_id [NENT];
  logic [4:0]  tbl_base [NENT];
  logic [4:0]  tbl_boost [NENT];

  sched_req_t  pending_reqs[$];
  sched_res_t  expected_results[$];
  int unsigned mismatches = 0;
  bit          taken = 1'b0;
  bit          calm = 1'b0;       // phases with no idling on either side
  int unsigned send_gap = 0, stall_len = 0;

  function automatic int unsigned pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  function automatic logic [4:0] eff_of(int unsigned i);
    logic [5:0] sum;
    sum = {1'b0, tbl_base[i]} + {1'b0, tbl_boost[i]};
    return (sum > {1'b0, mdl_max}) ? mdl_max : sum[4:0];
  endfunction

  // Store a state; freeing restores the default base and drops the boost.
  function automatic void store_state(int unsigned i, logic [2:0] st);
    if (st > ST_LAST) return;
    tbl_state[i] = st;
    if (st == ST_UNUSED) begin
      tbl_base[i] = mdl_default;
      tbl_boost[i] = '0;
    end
  endfunction

  // Apply one request to the model and queue the result it should produce.
  function automatic void schedule_step(sched_req_t r);
    sched_res_t res;
    bit         have;
    int unsigned best;
    logic [4:0] best_eff, e;
    res = '0;
    have = 1'b0;
    best = 0;
    best_eff = '0;
    case (r.req)
      REQ_PICK: begin
        for (int unsigned i = 0; i < NENT; i++) begin
          if (tbl_state[i] == ST_RUNNABLE) begin
            e = eff_of(i);
            if (!have || e > best_eff || (e == best_eff && tbl_id[i] < tbl_id[best])) begin
              have = 1'b1;
              best = i;
              best_eff = e;
            end
          end
        end
        if (have) begin
          tbl_state[best] = ST_RUNNING;
          tbl_boost[best] = '0;
          res.found = 1'b1;
          res.slot = best[5:0];
          res.tid = tbl_id[best];
          res.eff = best_eff;
        end
      end
      REQ_ADMIT: begin
        tbl_id[r.slot] = r.tid;
        tbl_base[r.slot] = r.bp;
        tbl_boost[r.slot] = r.ib;
        tbl_state[r.slot] = ST_RUNNABLE;
      end
      REQ_FINISH: begin
        store_state(32'(r.slot), r.ns);
        // Age every other runnable entry, saturating at prio_max.
        for (int unsigned i = 0; i < NENT; i++) begin
          if (i != 32'(r.slot) && tbl_state[i] == ST_RUNNABLE && tbl_base[i] < mdl_max &&
              tbl_boost[i] < mdl_max - tbl_base[i])
            tbl_boost[i] = tbl_boost[i] + 5'd1;
        end
      end
      REQ_SET_PRIO: begin
        if (r.bp < mdl_min || r.bp > mdl_max) begin
          res.err = 1'b1;
        end else begin
          tbl_base[r.slot] = r.bp;
          tbl_boost[r.slot] = '0;
        end
      end
      REQ_SET_STATE: store_state(32'(r.slot), r.ns);
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Request driver: advance on the falling edge once the held request is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken)) begin
      taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
    // Result stall: hold for a random stretch, then release.
    if (stall_len > 0) begin
      stall_len--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_len = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  // Monitor: predict on request acceptance, check on result acceptance.
  always @(posedge clk) begin
    sched_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        schedule_step(cur_req);
        taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found)
            report_mismatch("found", 32'(found), 32'(want.found));
          if (chosen_slot !== want.slot)
            report_mismatch("chosen_slot", 32'(chosen_slot), 32'(want.slot));
          if (chosen_id !== want.tid)
            report_mismatch("chosen_id", 32'(chosen_id), 32'(want.tid));
          if (chosen_eff !== want.eff)
            report_mismatch("chosen_eff_prio", 32'(chosen_eff), 32'(want.eff));
          if (error !== want.err)
            report_mismatch("error", 32'(error), 32'(want.err));
        end
      end
    end
  end

  // Register write with a setup and an access phase; the model takes the value once the access phase ends.
  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {27'($urandom_range(0, 32'h7ff_ffff)), val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      CFG_PRIO_MIN: mdl_min = val;
      CFG_PRIO_MAX: mdl_max = val;
      default:      mdl_default = val;
    endcase
  endtask

  function automatic sched_req_t mk(logic [2:0] req, logic [5:0] slot, logic [15:0] tid,
                                    logic [4:0] bp, logic [4:0] ib, logic [2:0] ns);
    sched_req_t r;
    r.req = req; r.slot = slot; r.tid = tid; r.bp = bp; r.ib = ib; r.ns = ns;
    return r;
  endfunction

  // Random request: admits and picks half the time, around a small slot pool so the
  // table fills, ties occur and aging saturates; some noise on top.
  function automatic sched_req_t rand_req();
    sched_req_t r;
    int unsigned k;
    r = mk(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
           16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)),
           5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)));
    k = $urandom_range(0, 99);
    if (k < 25) r.req = REQ_ADMIT;
    else if (k < 50) r.req = REQ_PICK;
    else if (k < 70) r.req = REQ_FINISH;
    else if (k < 80) r.req = REQ_SET_PRIO;
    else if (k < 94) r.req = REQ_SET_STATE;
    if ($urandom_range(0, 2) != 0) r.slot = 6'($urandom_range(0, 7));
    if ($urandom_range(0, 1) == 0) r.tid = 16'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) r.ns = ST_RUNNABLE;
    return r;
  endfunction

  // Poll at the rising edge, where the request valid is settled.
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [4:0] cfgs [5][3];
    cfgs = '{'{5'd0, 5'd31, 5'd10}, '{5'd5, 5'd20, 5'd3}, '{5'd31, 5'd0, 5'd31},
             '{5'd0, 5'd0, 5'd0}, '{5'd31, 5'd31, 5'd31}};
    mdl_min = 5'd0; mdl_max = 5'd31; mdl_default = 5'd10;
    for (int unsigned i = 0; i < NENT; i++) begin
      tbl_state[i] = ST_UNUSED; tbl_id[i] = '0; tbl_base[i] = 5'd10; tbl_boost[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pick, extremes, ties, saturation, rejects and unknown codes.
    pending_reqs.push_back(mk(REQ_PICK, 6'd0, 16'd0, 5'd0, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_ADMIT, 6'd63, 16'hffff, 5'd31, 5'd31, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_ADMIT, 6'd0, 16'd0, 5'd0, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_ADMIT, 6'd1, 16'd7, 5'd30, 5'd5, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_ADMIT, 6'd2, 16'd7, 5'd31, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_PICK, 6'd0, 16'd0, 5'd0, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_FINISH, 6'd1, 16'd0, 5'd0, 5'd0, ST_RUNNABLE));
    pending_reqs.push_back(mk(REQ_FINISH, 6'd5, 16'd0, 5'd0, 5'd0, 3'd7));
    pending_reqs.push_back(mk(REQ_PICK, 6'd0, 16'd0, 5'd0, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_SET_PRIO, 6'd0, 16'd0, 5'd31, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_SET_STATE, 6'd63, 16'd0, 5'd0, 5'd0, ST_SLEEPING));
    pending_reqs.push_back(mk(REQ_SET_STATE, 6'd0, 16'd0, 5'd0, 5'd0, 3'd6));
    pending_reqs.push_back(mk(REQ_SET_STATE, 6'd1, 16'd0, 5'd0, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_FINISH, 6'd2, 16'd0, 5'd0, 5'd0, ST_LAST));
    pending_reqs.push_back(mk(REQ_UNKNOWN, 6'd63, 16'hffff, 5'd31, 5'd31, 3'd7));
    pending_reqs.push_back(mk(3'd7, 6'd0, 16'd0, 5'd0, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_PICK, 6'd0, 16'd0, 5'd0, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_PICK, 6'd0, 16'd0, 5'd0, 5'd0, ST_UNUSED));
    drain();
    write_reg(CFG_PRIO_MIN, 5'd4);
    pending_reqs.push_back(mk(REQ_SET_PRIO, 6'd3, 16'd0, 5'd3, 5'd0, ST_UNUSED));
    pending_reqs.push_back(mk(REQ_SET_PRIO, 6'd3, 16'd0, 5'd4, 5'd0, ST_UNUSED));
    drain();

    // Random phases, one register setting each.
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_PRIO_MIN, cfgs[p][0]);
      write_reg(CFG_PRIO_MAX, cfgs[p][1]);
      write_reg(CFG_PRIO_DEFAULT, cfgs[p][2]);
      calm = (p == 3);
      repeat (160) pending_reqs.push_back(rand_req());
      drain();
    end

    repeat (140) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
